### rtl/core/lookahead_rms_compressor_defines.svh
// assertion macros for the lookahead rms compressor
`ifndef LOOKAHEAD_RMS_COMPRESSOR_DEFINES_SVH
`define LOOKAHEAD_RMS_COMPRESSOR_DEFINES_SVH

// condition must hold at every edge outside reset
`define LRC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("check failed");

// antecedent implies consequent in the cycle after
`define LRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("check failed");

`endif

### rtl/core/lrc_pkg.sv
// shared constants and types of the lookahead rms compressor
`default_nettype none
package lrc_pkg;
  localparam int SampleBits = 16;
  localparam int RingDepth  = 2048;
  localparam int PtrBits    = 11;
  localparam int FillBits   = 12;
  localparam int SumBits    = 41;
  localparam int MaxWindow  = 1024;
  localparam int MaxLook    = 1024;
  localparam int CfgIdxBits = 3;

  typedef logic [CfgIdxBits-1:0] cfg_idx_t;

  // register indexes of the configuration port
  localparam cfg_idx_t CFG_THRESHOLD = 3'd0;
  localparam cfg_idx_t CFG_SLOPE     = 3'd1;
  localparam cfg_idx_t CFG_BASE_GAIN = 3'd2;
  localparam cfg_idx_t CFG_ATTACK    = 3'd3;
  localparam cfg_idx_t CFG_RELEASE   = 3'd4;
  localparam cfg_idx_t CFG_WINDOW    = 3'd5;
  localparam cfg_idx_t CFG_LOOKAHEAD = 3'd6;

  // handshake between sequencer and divide/root unit
  typedef struct packed {
    logic busy;
    logic done;
  } dsq_status_t;
endpackage
`default_nettype wire

### rtl/core/lrc_in_if.sv
// input sample channel
`default_nettype none
interface lrc_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  sample_in;
  logic                end_of_stream;
  modport source (output valid, output sample_in, output end_of_stream, input ready);
  modport sink (input valid, input sample_in, input end_of_stream, output ready);
endinterface
`default_nettype wire

### rtl/core/lrc_out_if.sv
// result sample channel
`default_nettype none
interface lrc_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  sample_out;
  logic                last_out;
  modport source (output valid, output sample_out, output last_out, input ready);
  modport sink (input valid, input sample_out, input last_out, output ready);
endinterface
`default_nettype wire

### rtl/core/lrc_cfg_if.sv
// configuration write channel
`default_nettype none
interface lrc_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [lrc_pkg::CfgIdxBits-1:0] index;
  logic [15:0]             data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/lrc_divsqrt.sv
// iterative mean division followed by a digit-by-digit square root
`default_nettype none
module lrc_divsqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lrc_pkg::SumBits-1:0]   sum,
  input  wire logic [10:0]                   win,
  output lrc_pkg::dsq_status_t               status,
  output logic [15:0]                        rms
);
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT, S_DONE} dsq_state_t;

  dsq_state_t state_r;
  logic [5:0]  cnt_r;
  logic [10:0] win_r;
  logic [10:0] rem_r;
  logic [lrc_pkg::SumBits-1:0] quo_r;
  logic [43:0] rad_r;
  logic [24:0] srem_r;
  logic [21:0] root_r;

  logic [11:0] div_try;
  logic [24:0] sq_try;
  logic [24:0] sq_trial;

  always_comb begin
    div_try  = {rem_r, quo_r[lrc_pkg::SumBits-1]};
    sq_try   = {srem_r[22:0], rad_r[43:42]};
    sq_trial = {1'b0, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_DIV;
            cnt_r   <= 6'(lrc_pkg::SumBits - 1);
            quo_r   <= sum;
            win_r   <= win;
            rem_r   <= '0;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (div_try >= {1'b0, win_r}) begin
            rem_r <= 11'(div_try - {1'b0, win_r});
            quo_r <= {quo_r[lrc_pkg::SumBits-2:0], 1'b1};
          end else begin
            rem_r <= div_try[10:0];
            quo_r <= {quo_r[lrc_pkg::SumBits-2:0], 1'b0};
          end
          if (cnt_r == '0) begin
            state_r <= S_SQRT;
            cnt_r   <= 6'd21;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
          srem_r <= '0;
          root_r <= '0;
        end
        // one root bit per cycle, radicand is mean times four
        S_SQRT: begin
          if (sq_try >= sq_trial) begin
            srem_r <= sq_try - sq_trial;
            root_r <= {root_r[20:0], 1'b1};
          end else begin
            srem_r <= sq_try;
            root_r <= {root_r[20:0], 1'b0};
          end
          rad_r <= {rad_r[41:0], 2'b00};
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // load radicand on the last divide step
      if (state_r == S_DIV && cnt_r == '0) begin
        if (div_try >= {1'b0, win_r}) begin
          rad_r <= {1'b0, quo_r[lrc_pkg::SumBits-2:0], 1'b1, 2'b00};
        end else begin
          rad_r <= {1'b0, quo_r[lrc_pkg::SumBits-2:0], 1'b0, 2'b00};
        end
      end
    end
  end

  always_comb begin
    status.busy = (state_r != S_IDLE);
    status.done = (state_r == S_DONE);
    rms = (root_r[21:16] != '0) ? 16'hFFFF : root_r[15:0];
  end
endmodule
`default_nettype wire

### rtl/core/lookahead_rms_compressor.sv
// Lookahead rms compressor top level
//
// in_ch takes one Q1.15 sample per transaction; out_ch gives the compressed
// sample that left the lookahead delay, cfg_ch writes the seven registers
// (threshold, slope, base gain, attack, release, window, lookahead) and is
// always ready; write it only while the block is idle.
// Each input passes through an accept step and the ring update and check on
// the shared 18x18 multiplier; when it produces a result it then passes
// through the bit-serial mean divide, the bit-serial square root, a hand-off,
// the envelope, gain and output products on the same multiplier, and the
// final step. in_ch.ready is high only while the sequencer is idle.
// A result sits in an output register; the next sample is accepted while it
// waits, and the block only stalls at the end of the next sample that
// produces a result if the earlier result has still not been taken.
// Reset (rst_n low at a clock edge) restores register defaults and clears
// the stream state; the 2048-entry ring needs no clearing pass, since the
// fill count lets only data read from entries written in the current stream be used.
// After an end_of_stream sample the stream state returns to reset.
`default_nettype none
`include "lookahead_rms_compressor_defines.svh"
module lookahead_rms_compressor (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lrc_in_if.sink     in_ch,
  lrc_out_if.source  out_ch,
  lrc_cfg_if.sink    cfg_ch
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_ADDX, ST_SUBO, ST_CHK, ST_ROOT, ST_ENV1, ST_ENV2,
    ST_ENV3, ST_RED1, ST_RED2, ST_OUT1, ST_OUT2, ST_FIN
  } seq_state_t;

  seq_state_t state_r;

  // configuration registers
  logic [15:0]        thr_r, slope_r, att_r, rel_r;
  logic signed [15:0] base_r;
  logic [10:0]        win_cfg_r, look_cfg_r;

  // stream state
  logic [lrc_pkg::PtrBits-1:0]  wp_r;
  logic [lrc_pkg::FillBits-1:0] fill_r;
  logic [lrc_pkg::SumBits-1:0]  sum_r;
  logic [15:0]                  env_r;

  // per-item working registers
  logic signed [15:0] x_r, s_r;
  logic               eos_r, emit_r, above_r;
  logic [10:0]        w_r, d_r;
  logic [15:0]        rms_r, coef_r;
  logic [35:0]        acc_r;
  logic signed [17:0] gain_r;
  logic signed [15:0] q_r;

  // ring memory
  logic signed [15:0] ring_mem [lrc_pkg::RingDepth];
  logic signed [15:0] rd_data_r;
  logic               rd_en, wr_en;
  logic [lrc_pkg::PtrBits-1:0] rd_addr;

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod_r;

  // output register
  logic               out_valid_r, out_last_r;
  logic signed [15:0] out_data_r;

  logic [10:0] w_eff, l_eff;
  logic [lrc_pkg::FillBits-1:0] fill_inc;
  logic        dsq_start;
  lrc_pkg::dsq_status_t dsq_status;
  logic [15:0] dsq_rms;
  logic [35:0] env_sum, red_sum;
  logic signed [35:0] p_round;
  logic signed [23:0] q_full;
  logic        in_acc, fin_go;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.sample_out = out_data_r;
  assign out_ch.last_out = out_last_r;

  // effective window and lookahead
  always_comb begin
    w_eff = win_cfg_r;
    if (win_cfg_r == '0) w_eff = 11'd1;
    if (win_cfg_r > 11'(lrc_pkg::MaxWindow)) w_eff = 11'(lrc_pkg::MaxWindow);
    l_eff = look_cfg_r;
    if (look_cfg_r > 11'(lrc_pkg::MaxLook)) l_eff = 11'(lrc_pkg::MaxLook);
  end

  assign fill_inc = (fill_r == 12'(lrc_pkg::RingDepth)) ? fill_r : fill_r + 12'd1;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = wp_r - w_eff;
    wr_en   = (state_r == ST_SQX);
    if (state_r == ST_IDLE && in_acc) rd_en = 1'b1;
    if (state_r == ST_ADDX) begin
      rd_en   = 1'b1;
      rd_addr = wp_r - d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wp_r] <= x_r;
    if (rd_en) rd_data_r <= ring_mem[rd_addr];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQX: begin
        mul_a = 18'(x_r);
        mul_b = 18'(x_r);
      end
      ST_ADDX: begin
        mul_a = 18'(rd_data_r);
        mul_b = 18'(rd_data_r);
      end
      ST_ENV1: begin
        mul_a = {2'b00, rms_r};
        if (rms_r > env_r) mul_b = 18'(17'h10000 - {1'b0, att_r});
        else               mul_b = 18'(17'h10000 - {1'b0, rel_r});
      end
      ST_ENV2: begin
        mul_a = {2'b00, env_r};
        mul_b = {2'b00, coef_r};
      end
      ST_RED1: begin
        mul_a = {2'b00, 16'(env_r - thr_r)};
        mul_b = {2'b00, slope_r};
      end
      ST_OUT1: begin
        mul_a = 18'(s_r);
        mul_b = gain_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) prod_r <= mul_a * mul_b;

  assign env_sum = acc_r + prod_r + 36'd32768;
  assign red_sum = prod_r + 36'd32768;
  assign p_round = prod_r + 36'sd2048;
  assign q_full  = 24'(p_round >>> 12);
  assign dsq_start = (state_r == ST_CHK) && emit_r;
  assign fin_go = !emit_r || !out_valid_r || out_ch.ready;

  lrc_divsqrt u_divsqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dsq_start),
    .sum    (sum_r),
    .win    (w_r),
    .status (dsq_status),
    .rms    (dsq_rms)
  );

  // sequencer, stream state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= 16'd32768;
      slope_r     <= 16'd4096;
      base_r      <= 16'sd4096;
      att_r       <= '0;
      rel_r       <= '0;
      win_cfg_r   <= 11'd1;
      look_cfg_r  <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          lrc_pkg::CFG_THRESHOLD: thr_r      <= cfg_ch.data;
          lrc_pkg::CFG_SLOPE:     slope_r    <= cfg_ch.data;
          lrc_pkg::CFG_BASE_GAIN: base_r     <= cfg_ch.data;
          lrc_pkg::CFG_ATTACK:    att_r      <= cfg_ch.data;
          lrc_pkg::CFG_RELEASE:   rel_r      <= cfg_ch.data;
          lrc_pkg::CFG_WINDOW:    win_cfg_r  <= cfg_ch.data[10:0];
          lrc_pkg::CFG_LOOKAHEAD: look_cfg_r <= cfg_ch.data[10:0];
          default: ;
        endcase
      end
      // result valid: set at the end of an emitting item, cleared when taken
      if (state_r == ST_FIN && fin_go && emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            x_r     <= in_ch.sample_in;
            eos_r   <= in_ch.end_of_stream;
            w_r     <= w_eff;
            d_r     <= 11'(l_eff + w_eff - 11'd1);
            state_r <= ST_SQX;
          end
        end
        ST_SQX: state_r <= ST_ADDX;
        // add new square
        ST_ADDX: begin
          sum_r   <= sum_r + {5'd0, prod_r};
          state_r <= ST_SUBO;
        end
        // drop oldest square once the window is full
        ST_SUBO: begin
          if (fill_r >= {1'b0, w_r}) sum_r <= sum_r - {5'd0, prod_r};
          fill_r  <= fill_inc;
          s_r     <= rd_data_r;
          emit_r  <= (fill_inc >= ({1'b0, d_r} + 12'd1));
          state_r <= ST_CHK;
        end
        ST_CHK: state_r <= emit_r ? ST_ROOT : ST_FIN;
        ST_ROOT: begin
          if (dsq_status.done) begin
            rms_r   <= dsq_rms;
            state_r <= ST_ENV1;
          end
        end
        ST_ENV1: begin
          coef_r  <= (rms_r > env_r) ? att_r : rel_r;
          state_r <= ST_ENV2;
        end
        ST_ENV2: begin
          acc_r   <= prod_r;
          state_r <= ST_ENV3;
        end
        ST_ENV3: begin
          env_r   <= env_sum[31:16];
          state_r <= ST_RED1;
        end
        ST_RED1: begin
          above_r <= (env_r > thr_r);
          state_r <= ST_RED2;
        end
        // gain = base - rounded reduction, kept 18 bits wide
        ST_RED2: begin
          if (above_r) gain_r <= 18'(base_r) - {2'b00, red_sum[31:16]};
          else         gain_r <= 18'(base_r);
          state_r <= ST_OUT1;
        end
        ST_OUT1: state_r <= ST_OUT2;
        // round and saturate product
        ST_OUT2: begin
          if (q_full > 24'sd32767)       q_r <= 16'sh7FFF;
          else if (q_full < -24'sd32768) q_r <= -16'sh8000;
          else                           q_r <= q_full[15:0];
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            if (emit_r) begin
              out_data_r  <= q_r;
              out_last_r  <= eos_r;
            end
            wp_r <= eos_r ? '0 : wp_r + 11'd1;
            if (eos_r) begin
              fill_r <= '0;
              sum_r  <= '0;
              env_r  <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `LRC_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ch.ready)
  `LRC_ASSERT_ALWAYS(a_fill_bound, fill_r <= 12'(lrc_pkg::RingDepth))
  `LRC_ASSERT_ALWAYS(a_root_only_when_waited, !dsq_status.done || state_r == ST_ROOT)
  `LRC_ASSERT_NEXT(a_eos_clears, state_r == ST_FIN && fin_go && eos_r, fill_r == '0)
endmodule
`default_nettype wire
